/* src/mtx_pkg.sv */
// ----------------------------------------------------------------------------
// mtx_pkg
// Shared sizes, request/response codes and item types of the mutex table.
// ----------------------------------------------------------------------------
package mtx_pkg;

	localparam int NUM_MUTEXES = 32;
	localparam int NUM_TASKS   = 64;

	localparam int MUTEX_IDX_W = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
	localparam int TASK_IDX_W  = $clog2(NUM_TASKS);

	localparam int KIND_W    = 2;
	localparam int MUTEX_W   = 8;
	localparam int TASK_W    = 6;
	localparam int STATUS_W  = 3;
	localparam int CREATED_W = 5;
	localparam int COUNT_W   = 6;

	localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOCK   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_UNLOCK = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NONE_FREE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DEADLOCK  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_OWNER = 3'd4;
	localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd5;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [MUTEX_W-1:0] mutex_id;
		logic [TASK_W-1:0]  task_id;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [CREATED_W-1:0] created_id;
		logic                 woken_valid;
		logic [TASK_W-1:0]    woken_task;
		logic [COUNT_W-1:0]   caller_lock_count;
	} rsp_t;

	// one row of the mutex memory
	typedef struct packed {
		logic [TASK_W-1:0] holder;
		logic [TASK_W-1:0] head;
		logic [TASK_W-1:0] tail;
	} mutex_ent_t;

	localparam int MUTEX_ENT_W = $bits(mutex_ent_t);

endpackage

/* src/mutex_table_with_wait_queues_top.sv */
// ----------------------------------------------------------------------------
// mutex_table_with_wait_queues_top
// Mutex table with per-mutex FIFO wait queues and per-task held-lock counts.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one request item:
//   create, lock or unlock, a mutex number and the calling task.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one item per
//   request, in order.
// Timing:
//   A request is taken in the idle state; the memories are read on that edge
//   and the result is decided and written back in the exec state that follows.
//   An unlock that hands the mutex to a waiter needs a second read of the
//   link and count memories at the head task, done in a further hand state.
//   The result is written into the output register as the decision is made.
// Stall: the next request is accepted while a result waits in the output
//   register; the block holds its decision cycle until that register drains.
// Reset: all mutexes are free, unlocked and unqueued; every count reads zero.
//   No clearing pass is needed (flop valid bits cover the count memory).
// ----------------------------------------------------------------------------
module mutex_table_with_wait_queues_top
	import mtx_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_HAND
	} state_t;

	localparam int MW = MUTEX_IDX_W;
	localparam int TW = TASK_IDX_W;

	state_t state_q;

	logic [NUM_MUTEXES-1:0] allocated_q;
	logic [NUM_MUTEXES-1:0] locked_q;
	logic [NUM_MUTEXES-1:0] nonempty_q;
	logic [NUM_TASKS-1:0]   waiting_q;
	logic [NUM_TASKS-1:0]   cnt_vld_q;

	req_t               rq_s1;
	logic               cnt_vld_s1;
	logic [COUNT_W-1:0] caller_cnt_q;

	rsp_t rsp_q;
	logic rsp_valid_q;

	// memory ports
	logic                   m_we;
	mutex_ent_t             m_wdata;
	logic                   m_re;
	logic [MW-1:0]          m_raddr;
	logic [MUTEX_ENT_W-1:0] m_rbits;
	mutex_ent_t             m_rd;

	logic              nw_we;
	logic [TW-1:0]     nw_waddr;
	logic [TASK_W-1:0] nw_wdata;
	logic              nw_re;
	logic [TASK_W-1:0] nw_rd;

	logic               c_we;
	logic [TW-1:0]      c_waddr;
	logic [COUNT_W-1:0] c_wdata;
	logic               c_re;
	logic [TW-1:0]      c_raddr;
	logic [COUNT_W-1:0] c_rd;

	assign m_rd = mutex_ent_t'(m_rbits);

	mtx_ram #(.WIDTH(MUTEX_ENT_W), .DEPTH(NUM_MUTEXES)) u_mutex_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (rq_s1.mutex_id[MW-1:0]),
		.wdata (MUTEX_ENT_W'(m_wdata)),
		.re    (m_re),
		.raddr (m_raddr),
		.rdata (m_rbits)
	);

	mtx_ram #(.WIDTH(TASK_W), .DEPTH(NUM_TASKS)) u_link_ram (
		.clk   (clk),
		.we    (nw_we),
		.waddr (nw_waddr),
		.wdata (nw_wdata),
		.re    (nw_re),
		.raddr (TW'(m_rd.head)),
		.rdata (nw_rd)
	);

	mtx_ram #(.WIDTH(COUNT_W), .DEPTH(NUM_TASKS)) u_count_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.re    (c_re),
		.raddr (c_raddr),
		.rdata (c_rd)
	);

	// handshake
	logic accept;
	logic out_free;
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// request decode
	logic [MW-1:0]      mi;
	logic [TW-1:0]      ti;
	logic               task_ok;
	logic               m_ok;
	logic [COUNT_W-1:0] cnt_cur;
	logic [COUNT_W-1:0] cnt_up;
	logic [COUNT_W-1:0] cnt_dn;
	logic               free_found;
	logic [MW-1:0]      free_idx;

	assign mi      = rq_s1.mutex_id[MW-1:0];
	assign ti      = TW'(rq_s1.task_id);
	assign task_ok = (32'(rq_s1.task_id) < NUM_TASKS);
	assign m_ok    = (32'(rq_s1.mutex_id) < NUM_MUTEXES);
	assign cnt_cur = cnt_vld_s1 ? c_rd : '0;
	assign cnt_up  = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_W'(1);
	assign cnt_dn  = (cnt_cur == '0) ? cnt_cur : cnt_cur - COUNT_W'(1);

	// lowest free mutex
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int j = NUM_MUTEXES - 1; j >= 0; j--) begin
			if (!allocated_q[j]) begin
				free_found = 1'b1;
				free_idx   = MW'(j);
			end
		end
	end

	// decision
	logic               hand_go;
	logic               fire;
	logic               finish;
	rsp_t               rsp_n;
	logic               set_alloc;
	logic               set_locked;
	logic               clr_locked;
	logic               set_nonempty;
	logic               clr_nonempty;
	logic               set_waiting;
	logic               clr_waiting;
	logic [TW-1:0]      wake_idx;

	always_comb begin
		hand_go      = 1'b0;
		rsp_n        = '0;
		set_alloc    = 1'b0;
		set_locked   = 1'b0;
		clr_locked   = 1'b0;
		set_nonempty = 1'b0;
		clr_nonempty = 1'b0;
		set_waiting  = 1'b0;
		clr_waiting  = 1'b0;
		wake_idx     = TW'(m_rd.head);
		m_we         = 1'b0;
		m_wdata      = m_rd;
		nw_we        = 1'b0;
		nw_waddr     = TW'(m_rd.tail);
		nw_wdata     = rq_s1.task_id;
		c_we         = 1'b0;
		c_waddr      = ti;
		c_wdata      = cnt_cur;

		rsp_n.status            = ST_INVALID;
		rsp_n.caller_lock_count = task_ok ? cnt_cur : '0;

		unique case (state_q)
			S_EXEC: begin
				if (rq_s1.kind == KIND_CREATE) begin
					if (free_found) begin
						set_alloc        = 1'b1;
						rsp_n.status     = ST_OK;
						rsp_n.created_id = CREATED_W'(free_idx);
					end else begin
						rsp_n.status = ST_NONE_FREE;
					end
				end else if (rq_s1.kind == KIND_LOCK || rq_s1.kind == KIND_UNLOCK) begin
					if (!task_ok || !m_ok || !allocated_q[mi]) begin
						rsp_n.status = ST_INVALID;
					end else if (rq_s1.kind == KIND_LOCK) begin
						if (waiting_q[ti]) begin
							rsp_n.status = ST_INVALID;
						end else if (locked_q[mi] && m_rd.holder == rq_s1.task_id) begin
							rsp_n.status = ST_DEADLOCK;
						end else if (locked_q[mi]) begin
							// append caller to the wait queue
							nw_we        = nonempty_q[mi];
							m_we         = 1'b1;
							m_wdata.head = nonempty_q[mi] ? m_rd.head : rq_s1.task_id;
							m_wdata.tail = rq_s1.task_id;
							set_nonempty = 1'b1;
							set_waiting  = 1'b1;
							rsp_n.status = ST_QUEUED;
						end else begin
							m_we           = 1'b1;
							m_wdata.holder = rq_s1.task_id;
							set_locked     = 1'b1;
							c_we           = 1'b1;
							c_wdata        = cnt_up;
							rsp_n.status   = ST_OK;
							rsp_n.caller_lock_count = cnt_up;
						end
					end else begin
						if (!locked_q[mi] || m_rd.holder != rq_s1.task_id) begin
							rsp_n.status = ST_NOT_OWNER;
						end else begin
							c_we    = 1'b1;
							c_wdata = cnt_dn;
							rsp_n.status = ST_OK;
							rsp_n.caller_lock_count = cnt_dn;
							if (nonempty_q[mi]) begin
								hand_go = 1'b1;
							end else begin
								m_we           = 1'b1;
								m_wdata.holder = '0;
								clr_locked     = 1'b1;
							end
						end
					end
				end else begin
					rsp_n.status = ST_INVALID;
				end
			end
			S_HAND: begin
				// direct handoff to the oldest waiter
				m_we           = 1'b1;
				m_wdata.holder = m_rd.head;
				if (m_rd.head == m_rd.tail) begin
					clr_nonempty = 1'b1;
				end else begin
					m_wdata.head = nw_rd;
				end
				clr_waiting = 1'b1;
				c_we        = 1'b1;
				c_waddr     = wake_idx;
				c_wdata     = cnt_up;
				rsp_n.status            = ST_OK;
				rsp_n.woken_valid       = 1'b1;
				rsp_n.woken_task        = m_rd.head;
				rsp_n.caller_lock_count = caller_cnt_q;
			end
			default: begin
			end
		endcase

		fire   = ((state_q == S_EXEC) && (hand_go || out_free)) ||
		         ((state_q == S_HAND) && out_free);
		finish = fire && !hand_go;

		m_we  = m_we && fire;
		nw_we = nw_we && fire;
		c_we  = c_we && fire;
	end

	// read issue
	assign m_re    = accept;
	assign m_raddr = req.mutex_id[MW-1:0];
	assign nw_re   = fire && hand_go;
	assign c_re    = accept || (fire && hand_go);
	assign c_raddr = accept ? TW'(req.task_id) : TW'(m_rd.head);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			allocated_q  <= '0;
			locked_q     <= '0;
			nonempty_q   <= '0;
			waiting_q    <= '0;
			cnt_vld_q    <= '0;
			rq_s1        <= '0;
			cnt_vld_s1   <= 1'b0;
			caller_cnt_q <= '0;
			rsp_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (finish) begin
				rsp_q       <= rsp_n;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			if (c_re) begin
				cnt_vld_s1 <= cnt_vld_q[c_raddr];
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rq_s1   <= req;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (fire) begin
						state_q <= hand_go ? S_HAND : S_IDLE;
						caller_cnt_q <= rsp_n.caller_lock_count;
					end
				end
				S_HAND: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (fire) begin
				if (set_alloc)    allocated_q[free_idx] <= 1'b1;
				if (set_locked)   locked_q[mi]          <= 1'b1;
				if (clr_locked)   locked_q[mi]          <= 1'b0;
				if (set_nonempty) nonempty_q[mi]        <= 1'b1;
				if (clr_nonempty) nonempty_q[mi]        <= 1'b0;
				if (set_waiting)  waiting_q[ti]         <= 1'b1;
				if (clr_waiting)  waiting_q[wake_idx]   <= 1'b0;
				if (c_we)         cnt_vld_q[c_waddr]    <= 1'b1;
			end
		end
	end

endmodule

/* src/mtx_ram.sv */
// ----------------------------------------------------------------------------
// mtx_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mtx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
